FILE: rtl/hhmm_pkg.sv
package hhmm_pkg;

   // Four BCD digits: [0] minute ones, [1] minute tens, [2] hour ones, [3] hour tens
   typedef logic [3:0][3:0] digits_type;

   // Item kinds carried on tuser
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_KEY  = 1'b1;

   // Key codes
   localparam logic [2:0] KEY_WAKE   = 3'd0;
   localparam logic [2:0] KEY_FAST   = 3'd1;
   localparam logic [2:0] KEY_SLOW   = 3'd2;
   localparam logic [2:0] KEY_TOGGLE = 3'd3;
   localparam logic [2:0] KEY_OTHER  = 3'd4;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_TICKS_PER_MINUTE   = 2'd0;
   localparam logic [1:0] REG_DISPLAY_HOLD_TICKS = 2'd1;
   localparam logic [1:0] REG_SLOW_SET_DIVISOR   = 2'd2;

   localparam logic [7:0] TICKS_PER_MINUTE_RESET   = 8'd120;
   localparam logic [4:0] DISPLAY_HOLD_TICKS_RESET = 5'd21;
   localparam logic [5:0] SLOW_SET_DIVISOR_RESET   = 6'd50;

   localparam digits_type TIME_RESET  = {4'd0, 4'd0, 4'd0, 4'd0};
   localparam digits_type ALARM_RESET = {4'd0, 4'd7, 4'd0, 4'd0};

   // Segment bits
   localparam logic [6:0] SEG_A = 7'h01;
   localparam logic [6:0] SEG_B = 7'h02;
   localparam logic [6:0] SEG_C = 7'h04;
   localparam logic [6:0] SEG_D = 7'h08;
   localparam logic [6:0] SEG_E = 7'h10;
   localparam logic [6:0] SEG_F = 7'h20;
   localparam logic [6:0] SEG_G = 7'h40;

   typedef struct packed {
      logic [7:0] ticks_per_minute;
      logic [4:0] display_hold_ticks;
      logic [5:0] slow_set_divisor;
   } cfg_type;

   typedef struct packed {
      logic [6:0] seg_minute_ones;
      logic [6:0] seg_minute_tens;
      logic [6:0] seg_hour_ones;
      logic [6:0] seg_hour_tens;
      logic       display_active;
      logic       blink_lit;
      logic       alarm_sounding;
      logic       editing_alarm_out;
   } rsp_type;

   // Seven-segment code of one BCD digit; non-decimal codes stay dark
   function automatic logic [6:0] seg_code(input logic [3:0] digit);
      logic [6:0] code;
      case (digit)
         4'd0: code = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
         4'd1: code = SEG_B | SEG_C;
         4'd2: code = SEG_A | SEG_B | SEG_G | SEG_E | SEG_D;
         4'd3: code = SEG_A | SEG_B | SEG_G | SEG_C | SEG_D;
         4'd4: code = SEG_F | SEG_G | SEG_B | SEG_C;
         4'd5: code = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
         4'd6: code = SEG_A | SEG_F | SEG_E | SEG_D | SEG_C | SEG_G;
         4'd7: code = SEG_A | SEG_B | SEG_C;
         4'd8: code = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         4'd9: code = SEG_G | SEG_F | SEG_A | SEG_B | SEG_C | SEG_D;
         default: code = '0;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/hhmm_minute_inc.sv
module hhmm_minute_inc (
   input  hhmm_pkg::digits_type digits,
   output hhmm_pkg::digits_type digits_inc
);

   // Ripple one minute through the BCD digits, wrapping 24:00 to 00:00
   always_comb begin
      hhmm_pkg::digits_type d;
      d = digits;
      d[0] = d[0] + 4'd1;
      if (d[0] > 4'd9) begin
         d[0] = 4'd0;
         d[1] = d[1] + 4'd1;
      end
      if (d[1] > 4'd5) begin
         d[1] = 4'd0;
         d[2] = d[2] + 4'd1;
      end
      if (d[2] > 4'd9) begin
         d[2] = 4'd0;
         d[3] = d[3] + 4'd1;
      end
      if (d[3] == 4'd2 && d[2] == 4'd4) begin
         d = '0;
      end
      digits_inc = d;
   end

endmodule

FILE: rtl/hhmm_csr.sv
module hhmm_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output hhmm_pkg::cfg_type   cfg
);

   logic [7:0] ticks_per_minute_ff;
   logic [4:0] display_hold_ticks_ff;
   logic [5:0] slow_set_divisor_ff;
   logic       write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite;

   // Write registers on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_minute_ff   <= hhmm_pkg::TICKS_PER_MINUTE_RESET;
         display_hold_ticks_ff <= hhmm_pkg::DISPLAY_HOLD_TICKS_RESET;
         slow_set_divisor_ff   <= hhmm_pkg::SLOW_SET_DIVISOR_RESET;
      end else if (write_en) begin
         case (csr_paddr[3:2])
            hhmm_pkg::REG_TICKS_PER_MINUTE:   ticks_per_minute_ff   <= csr_pwdata[7:0];
            hhmm_pkg::REG_DISPLAY_HOLD_TICKS: display_hold_ticks_ff <= csr_pwdata[4:0];
            hhmm_pkg::REG_SLOW_SET_DIVISOR:   slow_set_divisor_ff   <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (csr_paddr[3:2])
         hhmm_pkg::REG_TICKS_PER_MINUTE:   csr_prdata = {24'd0, ticks_per_minute_ff};
         hhmm_pkg::REG_DISPLAY_HOLD_TICKS: csr_prdata = {27'd0, display_hold_ticks_ff};
         hhmm_pkg::REG_SLOW_SET_DIVISOR:   csr_prdata = {26'd0, slow_set_divisor_ff};
         default:                          csr_prdata = '0;
      endcase
   end

   assign cfg.ticks_per_minute   = ticks_per_minute_ff;
   assign cfg.display_hold_ticks = display_hold_ticks_ff;
   assign cfg.slow_set_divisor   = slow_set_divisor_ff;

endmodule

FILE: rtl/hhmm_core.sv
module hhmm_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic               op,
   input  logic [2:0]         key,
   input  hhmm_pkg::cfg_type  cfg,
   output hhmm_pkg::rsp_type  result
);

   hhmm_pkg::digits_type time_ff, time_in;
   hhmm_pkg::digits_type alarm_ff, alarm_in;
   hhmm_pkg::digits_type inc_src, inc_out, shown;
   logic [7:0] tick_count_ff, tick_count_in;
   logic [5:0] slow_count_ff, slow_count_in;
   logic       editing_ff, editing_in;
   logic       blink_ff, blink_in;
   logic       match_ff, match_in;
   logic       silenced_ff, silenced_in;
   logic [4:0] countdown_ff, countdown_in;
   logic       display_on;
   logic       editing_key;

   assign display_on = (countdown_ff != 5'd0);

   // Edit mode as seen by a key event after a possible toggle
   assign editing_key = (display_on && key == hhmm_pkg::KEY_TOGGLE) ? ~editing_ff : editing_ff;

   // One shared minute incrementer: time on ticks, the edited digits on keys
   assign inc_src = (op == hhmm_pkg::OP_KEY && editing_key) ? alarm_ff : time_ff;

   hhmm_minute_inc u_minute_inc (
      .digits     (inc_src),
      .digits_inc (inc_out)
   );

   // Next state for the item on the input
   always_comb begin
      logic [7:0] tick_sum;
      logic [5:0] slow_sum;
      logic       advance;
      time_in       = time_ff;
      alarm_in      = alarm_ff;
      tick_count_in = tick_count_ff;
      slow_count_in = slow_count_ff;
      editing_in    = editing_ff;
      blink_in      = blink_ff;
      match_in      = match_ff;
      silenced_in   = silenced_ff;
      countdown_in  = countdown_ff;
      tick_sum      = tick_count_ff + 8'd1;
      slow_sum      = slow_count_ff + 6'd1;
      advance       = 1'b0;
      if (op == hhmm_pkg::OP_TICK) begin
         blink_in = editing_ff ? ~blink_ff : 1'b1;
         if (tick_sum >= cfg.ticks_per_minute) begin
            time_in       = inc_out;
            slow_count_in = '0;
            tick_count_in = '0;
         end else begin
            tick_count_in = tick_sum;
         end
         if (time_in == alarm_ff) begin
            match_in = 1'b1;
         end else begin
            match_in    = 1'b0;
            silenced_in = 1'b0;
         end
         if (display_on) begin
            countdown_in = countdown_ff - 5'd1;
         end
         if (countdown_in == 5'd0) begin
            editing_in = 1'b0;
         end
      end else begin
         if (display_on) begin
            editing_in = editing_key;
            if (key == hhmm_pkg::KEY_FAST) begin
               advance = 1'b1;
            end else if (key == hhmm_pkg::KEY_SLOW) begin
               slow_count_in = slow_sum;
               advance       = (slow_sum >= cfg.slow_set_divisor);
            end
            if (advance) begin
               slow_count_in = '0;
               if (editing_key) begin
                  alarm_in = inc_out;
               end else begin
                  time_in = inc_out;
               end
            end
         end
         countdown_in = cfg.display_hold_ticks;
         if (match_ff) begin
            silenced_in = 1'b1;
         end
      end
   end

   // Commit state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff       <= hhmm_pkg::TIME_RESET;
         alarm_ff      <= hhmm_pkg::ALARM_RESET;
         tick_count_ff <= '0;
         slow_count_ff <= '0;
         editing_ff    <= 1'b0;
         blink_ff      <= 1'b0;
         match_ff      <= 1'b0;
         silenced_ff   <= 1'b0;
         countdown_ff  <= '0;
      end else if (step_en) begin
         time_ff       <= time_in;
         alarm_ff      <= alarm_in;
         tick_count_ff <= tick_count_in;
         slow_count_ff <= slow_count_in;
         editing_ff    <= editing_in;
         blink_ff      <= blink_in;
         match_ff      <= match_in;
         silenced_ff   <= silenced_in;
         countdown_ff  <= countdown_in;
      end
   end

   // Encode the digits on show from the updated state
   assign shown = editing_in ? alarm_in : time_in;

   assign result.seg_minute_ones   = hhmm_pkg::seg_code(shown[0]);
   assign result.seg_minute_tens   = hhmm_pkg::seg_code(shown[1]);
   assign result.seg_hour_ones     = hhmm_pkg::seg_code(shown[2]);
   assign result.seg_hour_tens     = hhmm_pkg::seg_code(shown[3]);
   assign result.display_active    = (countdown_in != 5'd0);
   assign result.blink_lit         = blink_in;
   assign result.alarm_sounding    = match_in & ~silenced_in;
   assign result.editing_alarm_out = editing_in;

endmodule

FILE: rtl/hhmm_alarm_clock_counter_unit.sv
// 24-hour HH:MM alarm clock with alarm, display hold and seven-segment output.
// Input stream (req_): one word per tick or key event; req_tuser is the kind
// (0 tick, 1 key), req_tdata[2:0] the key code, ignored for ticks.
// Result stream (rsp_): exactly one word per input word, carrying the segment
// codes of the four digits on show plus status flags; rsp_tuser is set when
// the digits shown are the alarm setting rather than the time.
// Configuration: APB-style port, always ready; ticks per minute at 0x0,
// display hold ticks at 0x4, slow-set divisor at 0x8. Write only while idle.
// The result appears on rsp_tvalid in the cycle after the word is taken.
// Throughput: one word per cycle; the whole update is a single pass through
// the BCD minute incrementer and compare, held in the result register.
// When the receiver stalls, the result register holds and req_tready drops
// until that result is taken; a word is accepted in the same cycle the held
// result leaves.
// Reset (synchronous, active high): time 00:00, alarm 07:00, display off,
// alarm quiet, registers at 120, 21 and 50, result register empty.
module hhmm_alarm_clock_counter_unit (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [2:0] key, [7:3] zero
   input  logic        req_tuser,    // [0] op
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [6:0] seg_minute_ones, [13:7] seg_minute_tens,
                                     // [20:14] seg_hour_ones, [27:21] seg_hour_tens,
                                     // [28] display_active, [29] blink_lit,
                                     // [30] alarm_sounding, [31] zero
   output logic        rsp_tuser,    // [0] editing_alarm_out
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   hhmm_pkg::cfg_type cfg;
   hhmm_pkg::rsp_type result;
   logic              req_accept;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_tdata_ff;
   logic              rsp_tuser_ff;

   hhmm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Take a word whenever the result register is empty or being emptied
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;

   hhmm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (req_accept),
      .op      (req_tuser),
      .key     (req_tdata[2:0]),
      .cfg     (cfg),
      .result  (result)
   );

   // Result register
   assign rsp_valid_in = req_accept | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tdata_ff <= {1'b0, result.alarm_sounding, result.blink_lit,
                          result.display_active, result.seg_hour_tens,
                          result.seg_hour_ones, result.seg_minute_tens,
                          result.seg_minute_ones};
         rsp_tuser_ff <= result.editing_alarm_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef SYNTHESIS
   // An accepted word always leaves a result behind it
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted word produced no result");

   // An empty result register never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty result register");

   // Shown digits stay decimal, so every digit lights at least one segment
   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[6:0] != 7'd0 && rsp_tdata[13:7] != 7'd0 &&
                      rsp_tdata[20:14] != 7'd0 && rsp_tdata[27:21] != 7'd0))
      else $error("non-decimal digit on the display");
`endif

endmodule
